### rtl/lps_pkg.sv
package lps_pkg;

    localparam int X_W   = 9;
    localparam int Y_W   = 8;
    localparam int C_W   = 16;
    localparam int OFS_W = 17;
    localparam int ERR_W = 12;

    // operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [X_W-1:0]   x_start;
        logic [Y_W-1:0]   y_start;
        logic [X_W-1:0]   x_end;
        logic [Y_W-1:0]   y_end;
        logic [C_W-1:0]   pixel_color;
    } cmd_t;

    typedef struct packed {
        logic [X_W-1:0]   pixel_x;
        logic [Y_W-1:0]   pixel_y;
        logic [OFS_W-1:0] pixel_offset;
        logic [C_W-1:0]   out_color;
        logic             last;
    } pix_t;

endpackage

### rtl/line_pixel_stepper_unit.sv
// Bresenham line rasteriser. Send a start item (operation = start) with both endpoints and a
// colour; the first endpoint comes back as a pixel item in the next cycle. Each step item then
// returns the next pixel along the line, with last set on the final endpoint; a step with no
// line in progress returns nothing, and a start abandons any line in progress. Endpoints are
// clamped to the screen. The whole step (an add and compare on the error term and one
// row-times-width multiply for the offset) sits between the line state and the output
// register, so a new item is taken every clock while the consumer keeps up.
// pixel_offset is row * SCREEN_WIDTH + column; the framebuffer base is added outside.
module line_pixel_stepper_unit #(
    parameter int SCREEN_WIDTH  = 384,
    parameter int SCREEN_HEIGHT = 216
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  lps_pkg::cmd_t cmd,
    output logic          pix_valid,
    input  logic          pix_ready,
    output lps_pkg::pix_t pix
);

    localparam int X_W   = lps_pkg::X_W;
    localparam int Y_W   = lps_pkg::Y_W;
    localparam int ERR_W = lps_pkg::ERR_W;
    localparam int OFS_W = lps_pkg::OFS_W;

    localparam int X_FMAX = (1 << X_W) - 1;
    localparam int Y_FMAX = (1 << Y_W) - 1;
    localparam int X_LIM  = (SCREEN_WIDTH - 1 > X_FMAX) ? X_FMAX : SCREEN_WIDTH - 1;
    localparam int Y_LIM  = (SCREEN_HEIGHT - 1 > Y_FMAX) ? Y_FMAX : SCREEN_HEIGHT - 1;
    localparam logic [X_W-1:0] X_MAX = X_LIM[X_W-1:0];
    localparam logic [Y_W-1:0] Y_MAX = Y_LIM[Y_W-1:0];

    localparam int PROD_W = Y_W + $clog2(SCREEN_WIDTH + 1) + 1;

    // line state
    logic [X_W-1:0]          cur_x_reg, cur_x_next;
    logic [Y_W-1:0]          cur_y_reg, cur_y_next;
    logic [X_W-1:0]          goal_x_reg, goal_x_next;
    logic [Y_W-1:0]          goal_y_reg, goal_y_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic [X_W:0]            tdx_reg, tdx_next;
    logic [Y_W:0]            tdy_reg, tdy_next;
    logic                    x_neg_reg, x_neg_next;
    logic                    y_neg_reg, y_neg_next;
    logic                    x_major_reg, x_major_next;
    logic                    active_reg, active_next;
    logic [lps_pkg::C_W-1:0] color_reg, color_next;

    // output register
    logic                    pix_valid_reg, pix_valid_next;
    lps_pkg::pix_t           pix_reg, pix_next;

    logic                    accept;
    logic                    is_start;

    // start path
    logic [X_W-1:0]          x1, x2, adx;
    logic [Y_W-1:0]          y1, y2, ady;
    logic                    s_xneg, s_yneg, s_xmaj;
    logic [X_W:0]            s_tdx;
    logic [Y_W:0]            s_tdy;

    // step path
    logic                    maj_neg, err_pos, err_zero, minor_mv;
    logic [X_W-1:0]          mv_x;
    logic [Y_W-1:0]          mv_y;
    logic signed [ERR_W:0]   err_wide;

    logic [X_W-1:0]          ox;
    logic [Y_W-1:0]          oy;
    logic                    ofin;
    logic [PROD_W-1:0]       prod;

    assign cmd_ready = !pix_valid_reg || pix_ready;
    assign accept    = cmd_valid && cmd_ready;
    assign is_start  = (cmd.operation == lps_pkg::OP_START);
    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    always_comb
    begin
        x1 = (cmd.x_start > X_MAX) ? X_MAX : cmd.x_start;
        x2 = (cmd.x_end   > X_MAX) ? X_MAX : cmd.x_end;
        y1 = (cmd.y_start > Y_MAX) ? Y_MAX : cmd.y_start;
        y2 = (cmd.y_end   > Y_MAX) ? Y_MAX : cmd.y_end;
        s_xneg = !(x2 > x1);
        s_yneg = !(y2 > y1);
        adx    = s_xneg ? (x1 - x2) : (x2 - x1);
        ady    = s_yneg ? (y1 - y2) : (y2 - y1);
        s_tdx  = {adx, 1'b0};
        s_tdy  = {ady, 1'b0};
        s_xmaj = (s_tdx >= (X_W+1)'(s_tdy));
    end

    always_comb
    begin
        maj_neg  = x_major_reg ? x_neg_reg : y_neg_reg;
        err_pos  = !err_reg[ERR_W-1] && (err_reg != '0);
        err_zero = (err_reg == '0);
        // on a tie the minor axis moves only when the major axis runs positive
        minor_mv = err_pos || (err_zero && !maj_neg);
        mv_x     = x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
        mv_y     = y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
    end

    always_comb
    begin
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        goal_x_next  = goal_x_reg;
        goal_y_next  = goal_y_reg;
        err_next     = err_reg;
        tdx_next     = tdx_reg;
        tdy_next     = tdy_reg;
        x_neg_next   = x_neg_reg;
        y_neg_next   = y_neg_reg;
        x_major_next = x_major_reg;
        active_next  = active_reg;
        color_next   = color_reg;
        err_wide     = {err_reg[ERR_W-1], err_reg};
        ox           = cur_x_reg;
        oy           = cur_y_reg;
        ofin         = 1'b0;

        if (is_start)
        begin
            x_neg_next   = s_xneg;
            y_neg_next   = s_yneg;
            tdx_next     = s_tdx;
            tdy_next     = s_tdy;
            x_major_next = s_xmaj;
            if (s_xmaj)
                err_wide = $signed((ERR_W+1)'(s_tdy)) - $signed((ERR_W+1)'(adx));
            else
                err_wide = $signed((ERR_W+1)'(s_tdx)) - $signed((ERR_W+1)'(ady));
            ox           = x1;
            oy           = y1;
            goal_x_next  = x2;
            goal_y_next  = y2;
            color_next   = cmd.pixel_color;
            ofin         = s_xmaj ? (x1 == x2) : (y1 == y2);
        end
        else if (x_major_reg)
        begin
            oy       = minor_mv ? mv_y : cur_y_reg;
            ox       = mv_x;
            err_wide = {err_reg[ERR_W-1], err_reg}
                     - (minor_mv ? $signed((ERR_W+1)'(tdx_reg)) : '0)
                     + $signed((ERR_W+1)'(tdy_reg));
            ofin     = (mv_x == goal_x_reg);
        end
        else
        begin
            ox       = minor_mv ? mv_x : cur_x_reg;
            oy       = mv_y;
            err_wide = {err_reg[ERR_W-1], err_reg}
                     - (minor_mv ? $signed((ERR_W+1)'(tdy_reg)) : '0)
                     + $signed((ERR_W+1)'(tdx_reg));
            ofin     = (mv_y == goal_y_reg);
        end

        if (accept && (is_start || active_reg))
        begin
            cur_x_next  = ox;
            cur_y_next  = oy;
            err_next    = err_wide[ERR_W-1:0];
            active_next = !ofin;
        end
        else
        begin
            x_neg_next   = x_neg_reg;
            y_neg_next   = y_neg_reg;
            tdx_next     = tdx_reg;
            tdy_next     = tdy_reg;
            x_major_next = x_major_reg;
            goal_x_next  = goal_x_reg;
            goal_y_next  = goal_y_reg;
            color_next   = color_reg;
        end
    end

    always_comb
    begin
        prod = PROD_W'(oy) * PROD_W'(SCREEN_WIDTH) + PROD_W'(ox);

        pix_next.pixel_x      = ox;
        pix_next.pixel_y      = oy;
        pix_next.pixel_offset = OFS_W'(prod);
        pix_next.out_color    = is_start ? cmd.pixel_color : color_reg;
        pix_next.last         = ofin;

        pix_valid_next = pix_valid_reg && !pix_ready;
        if (accept)
            pix_valid_next = is_start || active_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            err_reg       <= '0;
            tdx_reg       <= '0;
            tdy_reg       <= '0;
            x_neg_reg     <= 1'b0;
            y_neg_reg     <= 1'b0;
            x_major_reg   <= 1'b0;
            active_reg    <= 1'b0;
            color_reg     <= '0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            goal_x_reg    <= goal_x_next;
            goal_y_reg    <= goal_y_next;
            err_reg       <= err_next;
            tdx_reg       <= tdx_next;
            tdy_reg       <= tdy_next;
            x_neg_reg     <= x_neg_next;
            y_neg_reg     <= y_neg_next;
            x_major_reg   <= x_major_next;
            active_reg    <= active_next;
            color_reg     <= color_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            pix_reg <= pix_next;
    end

endmodule

### rtl/lps_checker.sv
module lps_checker #(
    parameter int SCREEN_WIDTH = 384
) (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_ready,
    input lps_pkg::cmd_t cmd,
    input logic          pix_valid,
    input logic          pix_ready,
    input lps_pkg::pix_t pix
);

    localparam int PROD_W = lps_pkg::Y_W + $clog2(SCREEN_WIDTH + 1) + 1;

    logic [PROD_W-1:0] exp_prod;

    assign exp_prod = PROD_W'(pix.pixel_y) * PROD_W'(SCREEN_WIDTH) + PROD_W'(pix.pixel_x);

    // a stalled pixel item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> pix_valid && $stable(pix))
        else $error("pixel item dropped or changed while stalled");

    // an empty output stage never blocks the input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_valid |-> cmd_ready)
        else $error("input stalled with empty output stage");

    // every start item yields its first pixel in the colour given
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd.operation == lps_pkg::OP_START)
        |=> pix_valid && (pix.out_color == $past(cmd.pixel_color)))
        else $error("start item gave no first pixel");

    a_offset: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid |-> pix.pixel_offset == lps_pkg::OFS_W'(exp_prod))
        else $error("pixel offset does not match position");

endmodule

bind line_pixel_stepper_unit lps_checker #(.SCREEN_WIDTH(SCREEN_WIDTH)) u_lps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix)
);

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int SCREEN_W     = 384;
    localparam int SCREEN_H     = 216;
    localparam int RANDOM_ITEMS = 820;
    localparam int QUIET_LIMIT  = 2000;

    logic           clk;
    logic           rst_n;
    logic           cmd_valid;
    logic           cmd_ready;
    lps_pkg::cmd_t  cmd;
    logic           pix_valid;
    logic           pix_ready;
    lps_pkg::pix_t  pix;

    // rasteriser state as the block should hold it
    int    line_x, line_y, end_x, end_y;
    int    err_term, dx2, dy2;
    bit    x_back, y_back, x_leads, drawing;
    int    line_color;

    lps_pkg::pix_t pending_pixels[$];
    int    fail_count = 0;
    int    items_sent = 0;
    bit    idle_on    = 1'b1;
    int    sink_hold  = 0;

    line_pixel_stepper_unit #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // work out the pixel an accepted item should produce, if any
    task automatic trace_pixel(input lps_pkg::cmd_t c);
        int            x1, y1, x2, y2;
        int            adx, ady;
        bit            fin;
        lps_pkg::pix_t p;
        if (c.operation == lps_pkg::OP_START)
        begin
            x1 = (c.x_start > SCREEN_W - 1) ? SCREEN_W - 1 : c.x_start;
            y1 = (c.y_start > SCREEN_H - 1) ? SCREEN_H - 1 : c.y_start;
            x2 = (c.x_end   > SCREEN_W - 1) ? SCREEN_W - 1 : c.x_end;
            y2 = (c.y_end   > SCREEN_H - 1) ? SCREEN_H - 1 : c.y_end;
            x_back   = !(x2 > x1);
            y_back   = !(y2 > y1);
            adx      = x_back ? x1 - x2 : x2 - x1;
            ady      = y_back ? y1 - y2 : y2 - y1;
            dx2      = 2 * adx;
            dy2      = 2 * ady;
            x_leads  = dx2 >= dy2;
            err_term = x_leads ? dy2 - adx : dx2 - ady;
            line_x   = x1;
            line_y   = y1;
            end_x    = x2;
            end_y    = y2;
            line_color = c.pixel_color;
            fin      = x_leads ? (x1 == x2) : (y1 == y2);
            drawing  = !fin;
        end
        else
        begin
            if (!drawing)
                return;
            // on a zero error the minor axis moves only if the major axis runs forward
            if (x_leads)
            begin
                if (err_term > 0 || (err_term == 0 && !x_back))
                begin
                    line_y   = y_back ? line_y - 1 : line_y + 1;
                    err_term -= dx2;
                end
                line_x   = x_back ? line_x - 1 : line_x + 1;
                err_term += dy2;
                fin      = (line_x == end_x);
            end
            else
            begin
                if (err_term > 0 || (err_term == 0 && !y_back))
                begin
                    line_x   = x_back ? line_x - 1 : line_x + 1;
                    err_term -= dy2;
                end
                line_y   = y_back ? line_y - 1 : line_y + 1;
                err_term += dx2;
                fin      = (line_y == end_y);
            end
            if (fin)
                drawing = 1'b0;
        end
        p.pixel_x      = lps_pkg::X_W'(line_x);
        p.pixel_y      = lps_pkg::Y_W'(line_y);
        p.pixel_offset = lps_pkg::OFS_W'(line_y * SCREEN_W + line_x);
        p.out_color    = lps_pkg::C_W'(line_color);
        p.last         = fin;
        pending_pixels.push_back(p);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && cmd_ready)
            trace_pixel(cmd);
    end

    always @(posedge clk)
    begin
        lps_pkg::pix_t want;
        if (rst_n && pix_valid && pix_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel x=%0d y=%0d offset=%0d color=%0h last=%0b",
                         $time, pix.pixel_x, pix.pixel_y, pix.pixel_offset,
                         pix.out_color, pix.last);
                fail_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("pixel_x",      want.pixel_x,      pix.pixel_x);
                check_field("pixel_y",      want.pixel_y,      pix.pixel_y);
                check_field("pixel_offset", want.pixel_offset, pix.pixel_offset);
                check_field("out_color",    want.out_color,    pix.out_color);
                check_field("last",         want.last,         pix.last);
            end
        end
    end

    // pixel consumer: random stalls, plus a long hold-off on request
    initial
    begin
        int sink_gap;
        sink_gap = 0;
        pix_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                pix_ready <= 1'b0;
                sink_hold--;
            end
            else if (sink_gap > 0)
            begin
                pix_ready <= 1'b0;
                sink_gap--;
            end
            else
            begin
                pix_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    sink_gap = pick_gap();
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (cmd_valid && cmd_ready) || (pix_valid && pix_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // valid is left high on return so back-to-back items need no extra edge
    task automatic send_item(input lps_pkg::cmd_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    function automatic lps_pkg::cmd_t make_cmd(input logic op, input int x1, input int y1,
                                               input int x2, input int y2, input int color);
        lps_pkg::cmd_t c;
        c.operation   = op;
        c.x_start     = lps_pkg::X_W'(x1);
        c.y_start     = lps_pkg::Y_W'(y1);
        c.x_end       = lps_pkg::X_W'(x2);
        c.y_end       = lps_pkg::Y_W'(y2);
        c.pixel_color = lps_pkg::C_W'(color);
        return c;
    endfunction

    // one start item, then step items whose other fields are junk
    task automatic draw_line(input int x1, input int y1, input int x2, input int y2,
                             input int color, input int steps);
        send_item(make_cmd(lps_pkg::OP_START, x1, y1, x2, y2, color));
        repeat (steps)
            send_item(make_cmd(lps_pkg::OP_STEP, $urandom, $urandom, $urandom, $urandom,
                               $urandom));
    endtask

    task automatic test_directed();
        send_item(make_cmd(lps_pkg::OP_STEP, 0, 0, 0, 0, 0));   // no line yet
        draw_line(0, 0, 0, 0, 16'h0000, 0);                  // single point
        draw_line(511, 255, 400, 240, 16'hFFFF, 0);          // both ends clip to one corner
        draw_line(383, 215, 381, 213, 16'hA5A5, 2);
        draw_line(0, 0, 2, 1, 16'h5A5A, 2);                  // zero error, major forward
        draw_line(2, 1, 0, 0, 16'h1234, 2);                  // zero error, major backward
        draw_line(10, 10, 11, 12, 16'h8001, 2);
        draw_line(11, 12, 10, 10, 16'h7FFE, 2);
        draw_line(100, 0, 100, 2, 16'h00FF, 2);              // vertical
        draw_line(383, 0, 381, 0, 16'hFF00, 2);              // horizontal
        draw_line(0, 215, 8, 200, 16'hC3C3, 1);              // abandoned by the next start
        draw_line(300, 100, 302, 100, 16'h3C3C, 4);          // steps run past the end
        wait_drained();
    endtask

    task automatic test_backpressure();
        idle_on   = 1'b0;
        sink_hold = 150;
        draw_line(10, 10, 40, 20, 16'hBEEF, 30);
        wait_drained();
        idle_on = 1'b1;
    endtask

    task automatic test_random_lines();
        int            x1, y1, x2, y2, cx1, cy1, cx2, cy2, steps, kind;
        lps_pkg::cmd_t c;
        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 39) == 0)
                idle_on = !idle_on;
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                c.operation   = 1'($urandom_range(0, 1));
                c.x_start     = lps_pkg::X_W'($urandom);
                c.y_start     = lps_pkg::Y_W'($urandom);
                c.x_end       = lps_pkg::X_W'($urandom);
                c.y_end       = lps_pkg::Y_W'($urandom);
                c.pixel_color = lps_pkg::C_W'($urandom);
                send_item(c);
            end
            else
            begin
                x1 = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 383);
                y1 = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 215);
                if ($urandom_range(0, 39) == 0)
                begin
                    x2 = $urandom_range(0, 511);
                    y2 = $urandom_range(0, 255);
                end
                else
                begin
                    x2 = x1 + $urandom_range(0, 24) - 12;
                    y2 = y1 + $urandom_range(0, 24) - 12;
                    x2 = (x2 < 0) ? 0 : (x2 > 511) ? 511 : x2;
                    y2 = (y2 < 0) ? 0 : (y2 > 255) ? 255 : y2;
                end
                cx1 = (x1 > SCREEN_W - 1) ? SCREEN_W - 1 : x1;
                cy1 = (y1 > SCREEN_H - 1) ? SCREEN_H - 1 : y1;
                cx2 = (x2 > SCREEN_W - 1) ? SCREEN_W - 1 : x2;
                cy2 = (y2 > SCREEN_H - 1) ? SCREEN_H - 1 : y2;
                steps = (cx2 > cx1) ? cx2 - cx1 : cx1 - cx2;
                if (((cy2 > cy1) ? cy2 - cy1 : cy1 - cy2) > steps)
                    steps = (cy2 > cy1) ? cy2 - cy1 : cy1 - cy2;
                if (kind == 1)
                    steps = $urandom_range(0, steps);
                else if (kind == 2)
                    steps = steps + $urandom_range(1, 3);
                draw_line(x1, y1, x2, y2, $urandom_range(0, 65535), steps);
            end
        end
        wait_drained();
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random_lines();

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
